[rtl/core/hrcd_pkg.sv]
// Package for the HTTP response header and chunked body decoder: types, constants, helpers.
package hrcd_pkg;

  localparam int MAX_HEADERS  = 1024;
  localparam int HEADER_BYTES = 1048576;
  localparam int SIZE_BITS    = 24;

  localparam int HDR_CNT_W  = 11;
  localparam int HDR_BYTE_W = $clog2(HEADER_BYTES);
  localparam int LIMIT_W    = 11;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);
  localparam logic [LIMIT_W-1:0] LIMIT_CAP   = LIMIT_W'(MAX_HEADERS);
  localparam logic [HDR_BYTE_W-1:0] HDR_BYTE_LAST = HDR_BYTE_W'(HEADER_BYTES - 1);

  localparam int NAME_LEN  = 17;
  localparam int VALUE_LEN = 7;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'd58;

  // Register index of header_limit (word index taken from paddr[2])
  localparam logic REG_HEADER_LIMIT = 1'b0;

  typedef enum logic [3:0] {
    CLS_NAME       = 4'd0,
    CLS_SEPARATOR  = 4'd1,
    CLS_VALUE      = 4'd2,
    CLS_LINE_END   = 4'd3,
    CLS_HDR_END    = 4'd4,
    CLS_BODY_DATA  = 4'd5,
    CLS_FRAMING    = 4'd6,
    CLS_BODY_END   = 4'd7,
    CLS_IGNORED    = 4'd8,
    CLS_OVERFLOW   = 4'd9,
    CLS_TOO_LONG   = 4'd10,
    CLS_SATURATED  = 4'd11
  } byte_class_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [3:0]           byte_class;
    logic [7:0]           data_byte;
    logic                 chunked_mode;
    logic [HDR_CNT_W-1:0] header_number;
  } result_t;

  // Characters of "Transfer-Encoding"
  function automatic logic [7:0] name_char(input logic [4:0] pos);
    logic [7:0] c;
    case (pos)
      5'd0:    c = "T";
      5'd1:    c = "r";
      5'd2:    c = "a";
      5'd3:    c = "n";
      5'd4:    c = "s";
      5'd5:    c = "f";
      5'd6:    c = "e";
      5'd7:    c = "r";
      5'd8:    c = "-";
      5'd9:    c = "E";
      5'd10:   c = "n";
      5'd11:   c = "c";
      5'd12:   c = "o";
      5'd13:   c = "d";
      5'd14:   c = "i";
      5'd15:   c = "n";
      5'd16:   c = "g";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Characters of "chunked"
  function automatic logic [7:0] value_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "c";
      4'd1:    c = "h";
      4'd2:    c = "u";
      4'd3:    c = "n";
      4'd4:    c = "k";
      4'd5:    c = "e";
      4'd6:    c = "d";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Bit 4: byte is a hex digit; bits 3:0: its value
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= "a" && b <= "f") begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= "A" && b <= "F") begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

[rtl/core/http_response_header_chunk_decoder_top.sv]
// Top level of the HTTP response header scanner and chunked body decoder.
//
//  Channel   Signals                                   Transfer when
//  --------  ----------------------------------------  -----------------------------------
//  input     item_valid, item_ready, item              item_valid && item_ready
//  result    result_valid, result_ready, result        result_valid && result_ready
//  config    psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite && pready
//            prdata, pready
//
//  One byte per cycle while item_ready is high: each accepted byte is classified by
//  one pass of logic between the parse state registers and the result register, and its
//  result is registered into the head entry, or into the skid entry if the head is held.
//  A two-entry result buffer (head plus skid) keeps input flowing for one more
//  byte while a result waits; item_ready drops only once the skid entry is full.
//  rst is synchronous, active high: clears parse state, result valids, and
//  reloads header_limit with 1000. No clearing pass is needed.
module http_response_header_chunk_decoder_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  hrcd_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output hrcd_pkg::result_t                   result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hrcd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [hrcd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [hrcd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  typedef enum logic [3:0] {
    PH_NAME  = 4'd0,
    PH_SKIP  = 4'd1,
    PH_VALUE = 4'd2,
    PH_SIZE  = 4'd3,
    PH_DATA  = 4'd4,
    PH_TRAIL = 4'd5,
    PH_DONE  = 4'd6,
    PH_ERROR = 4'd7
  } phase_t;

  typedef struct packed {
    phase_t                             phase;
    logic                               last_was_cr;
    logic                               line_has_bytes;
    logic                               colon_seen;
    logic [hrcd_pkg::HDR_CNT_W-1:0]     line_count;
    logic [hrcd_pkg::HDR_BYTE_W-1:0]    header_byte_count;
    logic [4:0]                         name_match_pos;
    logic                               name_still_matches;
    logic [3:0]                         value_match_pos;
    logic                               value_still_matches;
    logic                               encoding_header_found;
    logic                               chunked_flag;
    logic [hrcd_pkg::SIZE_BITS-1:0]     chunk_remaining;
    logic                               hex_ended;
    logic [1:0]                         trailer_skip;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:                 PH_NAME,
    last_was_cr:           1'b0,
    line_has_bytes:        1'b0,
    colon_seen:            1'b0,
    line_count:            '0,
    header_byte_count:     '0,
    name_match_pos:        5'd0,
    name_still_matches:    1'b1,
    value_match_pos:       4'd0,
    value_still_matches:   1'b1,
    encoding_header_found: 1'b0,
    chunked_flag:          1'b0,
    chunk_remaining:       '0,
    hex_ended:             1'b0,
    trailer_skip:          2'd0
  };

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [hrcd_pkg::LIMIT_W-1:0] header_limit;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= hrcd_pkg::LIMIT_RESET;
    end else if (cfg_write && paddr[2] == hrcd_pkg::REG_HEADER_LIMIT) begin
      header_limit <= pwdata[hrcd_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == hrcd_pkg::REG_HEADER_LIMIT) begin
      prdata = {{(hrcd_pkg::APB_DATA_W - hrcd_pkg::LIMIT_W){1'b0}}, header_limit};
    end
  end

  // Effective line-count limit: the register is capped at MAX_HEADERS
  logic [hrcd_pkg::LIMIT_W-1:0] line_limit;
  assign line_limit = (header_limit > hrcd_pkg::LIMIT_CAP) ? hrcd_pkg::LIMIT_CAP : header_limit;

  // ---------------------------------------------------------------------------
  // Result buffer: head register plus one skid entry
  // ---------------------------------------------------------------------------
  logic              head_valid;
  logic              skid_valid;
  hrcd_pkg::result_t head;
  hrcd_pkg::result_t skid;
  hrcd_pkg::result_t res_next;
  logic              accept;
  logic              out_fire;

  assign item_ready   = !skid_valid;
  assign accept       = item_valid && item_ready;
  assign result_valid = head_valid;
  assign result       = head;
  assign out_fire     = head_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept && out_fire) begin
        // One in, one out: skid (if any) advances into head
        if (skid_valid) begin
          head <= skid;
          skid <= res_next;
        end else begin
          head <= res_next;
        end
      end else if (accept) begin
        if (!head_valid) begin
          head       <= res_next;
          head_valid <= 1'b1;
        end else begin
          skid       <= res_next;
          skid_valid <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid) begin
          head       <= skid;
          skid_valid <= 1'b0;
        end else begin
          head_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Parse state and per-byte classification
  // ---------------------------------------------------------------------------
  parse_state_t pstate;
  parse_state_t pstate_next;
  parse_state_t st;
  logic [7:0]   b;
  logic [3:0]   cls;
  logic         line_done;
  logic [4:0]   hex;

  assign b   = item.stream_byte;
  assign hex = hrcd_pkg::hex_value(b);

  always_comb begin
    // Restart clears parse state ahead of this byte
    st          = item.restart ? PARSE_RESET : pstate;
    pstate_next = st;
    cls         = hrcd_pkg::CLS_IGNORED;
    line_done   = 1'b0;

    case (st.phase)
      PH_NAME, PH_SKIP, PH_VALUE: begin
        if (st.header_byte_count >= hrcd_pkg::HDR_BYTE_LAST) begin
          pstate_next.phase = PH_ERROR;
          cls               = hrcd_pkg::CLS_TOO_LONG;
        end else begin
          pstate_next.header_byte_count =
            st.header_byte_count + hrcd_pkg::HDR_BYTE_W'(1);
          if (st.last_was_cr) begin
            pstate_next.last_was_cr = 1'b0;
            if (b == hrcd_pkg::CH_LF) begin
              line_done = 1'b1;
              if (st.line_count >= line_limit) begin
                pstate_next.phase = PH_ERROR;
                cls               = hrcd_pkg::CLS_OVERFLOW;
              end else if (!st.line_has_bytes) begin
                // Empty line: headers end
                if (st.chunked_flag) begin
                  pstate_next.phase           = PH_SIZE;
                  pstate_next.chunk_remaining = '0;
                  pstate_next.hex_ended       = 1'b0;
                  pstate_next.trailer_skip    = 2'd0;
                end else begin
                  pstate_next.phase = PH_DONE;
                end
                cls = hrcd_pkg::CLS_HDR_END;
              end else begin
                if (!st.encoding_header_found && st.name_still_matches &&
                    st.name_match_pos == 5'(hrcd_pkg::NAME_LEN)) begin
                  pstate_next.encoding_header_found = 1'b1;
                  pstate_next.chunked_flag = st.colon_seen && st.value_still_matches &&
                                             st.value_match_pos == 4'(hrcd_pkg::VALUE_LEN);
                end
                pstate_next.line_count          = st.line_count + hrcd_pkg::HDR_CNT_W'(1);
                pstate_next.line_has_bytes      = 1'b0;
                pstate_next.colon_seen          = 1'b0;
                pstate_next.name_match_pos      = 5'd0;
                pstate_next.name_still_matches  = 1'b1;
                pstate_next.value_match_pos     = 4'd0;
                pstate_next.value_still_matches = 1'b1;
                pstate_next.phase               = PH_NAME;
                cls                             = hrcd_pkg::CLS_LINE_END;
              end
            end else begin
              // Lone CR is content of the current part of the line
              pstate_next.line_has_bytes = 1'b1;
              if (st.phase == PH_NAME) begin
                pstate_next.name_still_matches = 1'b0;
              end else begin
                pstate_next.value_still_matches = 1'b0;
              end
            end
          end

          if (!line_done) begin
            if (st.phase == PH_SKIP) begin
              pstate_next.phase = PH_VALUE;
              if (b == hrcd_pkg::CH_CR) begin
                pstate_next.last_was_cr         = 1'b1;
                pstate_next.value_still_matches = 1'b0;
              end
              cls = hrcd_pkg::CLS_SEPARATOR;
            end else if (b == hrcd_pkg::CH_CR) begin
              pstate_next.last_was_cr = 1'b1;
              cls = (st.phase == PH_NAME) ? hrcd_pkg::CLS_NAME : hrcd_pkg::CLS_VALUE;
            end else begin
              pstate_next.line_has_bytes = 1'b1;
              if (st.phase == PH_NAME) begin
                if (b == hrcd_pkg::CH_COLON) begin
                  pstate_next.colon_seen = 1'b1;
                  pstate_next.phase      = PH_SKIP;
                  cls                    = hrcd_pkg::CLS_SEPARATOR;
                end else begin
                  if (pstate_next.name_still_matches &&
                      pstate_next.name_match_pos < 5'(hrcd_pkg::NAME_LEN) &&
                      b == hrcd_pkg::name_char(pstate_next.name_match_pos)) begin
                    pstate_next.name_match_pos = pstate_next.name_match_pos + 5'd1;
                  end else begin
                    pstate_next.name_still_matches = 1'b0;
                  end
                  cls = hrcd_pkg::CLS_NAME;
                end
              end else begin
                if (pstate_next.value_still_matches &&
                    pstate_next.value_match_pos < 4'(hrcd_pkg::VALUE_LEN) &&
                    b == hrcd_pkg::value_char(pstate_next.value_match_pos)) begin
                  pstate_next.value_match_pos = pstate_next.value_match_pos + 4'd1;
                end else begin
                  pstate_next.value_still_matches = 1'b0;
                end
                cls = hrcd_pkg::CLS_VALUE;
              end
            end
          end
        end
      end

      PH_SIZE: begin
        cls = hrcd_pkg::CLS_FRAMING;
        if (st.last_was_cr && b == hrcd_pkg::CH_LF) begin
          pstate_next.last_was_cr = 1'b0;
          if (st.chunk_remaining == '0) begin
            pstate_next.phase = PH_DONE;
            cls               = hrcd_pkg::CLS_BODY_END;
          end else begin
            pstate_next.phase = PH_DATA;
          end
        end else begin
          pstate_next.last_was_cr = (b == hrcd_pkg::CH_CR);
          if (!st.hex_ended && hex[4]) begin
            if (st.chunk_remaining[hrcd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
              // Next digit would overflow: pin at all ones
              pstate_next.chunk_remaining = '1;
              cls                         = hrcd_pkg::CLS_SATURATED;
            end else begin
              pstate_next.chunk_remaining =
                {st.chunk_remaining[hrcd_pkg::SIZE_BITS-5:0], hex[3:0]};
            end
          end else begin
            pstate_next.hex_ended = 1'b1;
          end
        end
      end

      PH_DATA: begin
        cls = hrcd_pkg::CLS_BODY_DATA;
        if (st.chunk_remaining != '0) begin
          pstate_next.chunk_remaining = st.chunk_remaining - hrcd_pkg::SIZE_BITS'(1);
        end
        if (pstate_next.chunk_remaining == '0) begin
          pstate_next.phase        = PH_TRAIL;
          pstate_next.trailer_skip = 2'd2;
        end
      end

      PH_TRAIL: begin
        cls = hrcd_pkg::CLS_FRAMING;
        if (st.trailer_skip != 2'd0) begin
          pstate_next.trailer_skip = st.trailer_skip - 2'd1;
        end
        if (pstate_next.trailer_skip == 2'd0) begin
          pstate_next.phase           = PH_SIZE;
          pstate_next.chunk_remaining = '0;
          pstate_next.hex_ended       = 1'b0;
          pstate_next.last_was_cr     = 1'b0;
        end
      end

      default: begin
        cls = hrcd_pkg::CLS_IGNORED;
      end
    endcase

    res_next.byte_class    = cls;
    res_next.data_byte     = b;
    res_next.chunked_mode  = pstate_next.chunked_flag && (pstate_next.phase >= PH_SIZE);
    res_next.header_number = pstate_next.line_count;
  end

  // Advance parse state only on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= PARSE_RESET;
    end else if (accept) begin
      pstate <= pstate_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry valid while head is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && head_valid && !result_ready) |=> skid_valid)
    else $error("stalled transfer not held in skid entry");

  a_data_only_chunked: assert property (@(posedge clk) disable iff (rst)
    (head_valid && head.byte_class == hrcd_pkg::CLS_BODY_DATA) |-> head.chunked_mode)
    else $error("body data reported outside chunked mode");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    pstate.line_count <= hrcd_pkg::HDR_CNT_W'(hrcd_pkg::MAX_HEADERS))
    else $error("header count beyond limit");

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (pstate.phase == PH_DATA) |-> (pstate.chunk_remaining != '0))
    else $error("data phase with nothing left in chunk");

endmodule

[verif/http_response_header_chunk_decoder_top_tb.sv]
// Self-checking testbench for the HTTP response header scanner and chunked body decoder.
module http_response_header_chunk_decoder_top_tb;
  import hrcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned MAX_REPORTS   = 20;
  localparam int unsigned LIMIT_AT_RESET = 1000;
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_HEADER_LIMIT, 2'b00};

  // Parse position of the decoder; the order matters, everything from
  // BODY_SIZE on lies past the header section.
  typedef enum logic [2:0] {
    HDR_NAME, HDR_SKIP, HDR_VALUE, BODY_SIZE, BODY_DATA, BODY_TRAIL, BODY_DONE, PARSE_ERROR
  } parse_phase_t;

  // Tracks the parse of the byte stream and holds the classification that each
  // accepted byte must produce, oldest first.
  class parse_tracker;
    logic [LIMIT_W-1:0]   limit;
    parse_phase_t         phase;
    bit                   last_cr, has_bytes, colon, name_ok, val_ok;
    bit                   enc_found, chunked, hex_done;
    int unsigned          hdr_cnt, hdr_bytes, name_pos, val_pos, trail;
    logic [SIZE_BITS-1:0] remaining;
    string                te_name, te_value;
    result_t              awaited[$];
    int unsigned          errors, checked;

    function new();
      te_name  = "Transfer-Encoding";
      te_value = "chunked";
      limit    = LIMIT_W'(LIMIT_AT_RESET);
      errors   = 0;
      checked  = 0;
      clear_parse();
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void clear_line();
      last_cr   = 0;
      has_bytes = 0;
      colon     = 0;
      name_pos  = 0;
      name_ok   = 1;
      val_pos   = 0;
      val_ok    = 1;
    endfunction

    function void clear_parse();
      phase = HDR_NAME;
      clear_line();
      hdr_cnt   = 0;
      hdr_bytes = 0;
      enc_found = 0;
      chunked   = 0;
      remaining = '0;
      hex_done  = 0;
      trail     = 0;
    endfunction

    function void start_size_line();
      phase     = BODY_SIZE;
      remaining = '0;
      hex_done  = 0;
      last_cr   = 0;
      trail     = 0;
    endfunction

    function int hex_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - 48;
      if (b >= "a" && b <= "f") return int'(b) - 87;
      if (b >= "A" && b <= "F") return int'(b) - 55;
      return -1;
    endfunction

    function byte_class_t header_step(logic [7:0] b);
      int unsigned cap;
      if (hdr_bytes >= HEADER_BYTES - 1) begin
        phase = PARSE_ERROR;
        return CLS_TOO_LONG;
      end
      hdr_bytes++;
      if (last_cr) begin
        last_cr = 0;
        if (b == CH_LF) begin
          cap = (limit > MAX_HEADERS) ? MAX_HEADERS : limit;
          if (hdr_cnt >= cap) begin
            phase = PARSE_ERROR;
            return CLS_OVERFLOW;
          end
          if (!has_bytes) begin
            if (chunked) start_size_line();
            else phase = BODY_DONE;
            return CLS_HDR_END;
          end
          // only the first header with the exact name decides the mode
          if (!enc_found && name_ok && name_pos == te_name.len()) begin
            enc_found = 1;
            chunked   = colon && val_ok && val_pos == te_value.len();
          end
          hdr_cnt++;
          clear_line();
          phase = HDR_NAME;
          return CLS_LINE_END;
        end
        // a lone CR becomes content of the part it sits in
        has_bytes = 1;
        if (phase == HDR_NAME) name_ok = 0;
        else val_ok = 0;
      end
      if (phase == HDR_SKIP) begin
        phase = HDR_VALUE;
        if (b == CH_CR) begin
          last_cr = 1;
          val_ok  = 0;
        end
        return CLS_SEPARATOR;
      end
      if (b == CH_CR) begin
        last_cr = 1;
        return (phase == HDR_NAME) ? CLS_NAME : CLS_VALUE;
      end
      has_bytes = 1;
      if (phase == HDR_NAME) begin
        if (b == CH_COLON) begin
          colon = 1;
          phase = HDR_SKIP;
          return CLS_SEPARATOR;
        end
        if (name_ok && name_pos < te_name.len() && b == te_name[name_pos]) name_pos++;
        else name_ok = 0;
        return CLS_NAME;
      end
      if (val_ok && val_pos < te_value.len() && b == te_value[val_pos]) val_pos++;
      else val_ok = 0;
      return CLS_VALUE;
    endfunction

    function byte_class_t size_step(logic [7:0] b);
      int d;
      if (last_cr && b == CH_LF) begin
        last_cr = 0;
        if (remaining == 0) begin
          phase = BODY_DONE;
          return CLS_BODY_END;
        end
        phase = BODY_DATA;
        return CLS_FRAMING;
      end
      last_cr = (b == CH_CR);
      d = hex_of(b);
      if (!hex_done && d >= 0) begin
        if ((remaining >> (SIZE_BITS - 4)) != 0) begin
          remaining = '1;
          return CLS_SATURATED;
        end
        remaining = {remaining[SIZE_BITS-5:0], 4'(d)};
        return CLS_FRAMING;
      end
      hex_done = 1;
      return CLS_FRAMING;
    endfunction

    function result_t classify(item_t it);
      byte_class_t cls;
      result_t     r;
      if (it.restart) clear_parse();
      case (phase)
        HDR_NAME, HDR_SKIP, HDR_VALUE: cls = header_step(it.stream_byte);
        BODY_SIZE: cls = size_step(it.stream_byte);
        BODY_DATA: begin
          cls = CLS_BODY_DATA;
          if (remaining != 0) remaining--;
          if (remaining == 0) begin
            phase = BODY_TRAIL;
            trail = 2;
          end
        end
        BODY_TRAIL: begin
          cls = CLS_FRAMING;
          if (trail > 0) trail--;
          if (trail == 0) start_size_line();
        end
        default: cls = CLS_IGNORED;
      endcase
      r.byte_class    = cls;
      r.data_byte     = it.stream_byte;
      r.chunked_mode  = chunked && (phase >= BODY_SIZE);
      r.header_number = HDR_CNT_W'(hdr_cnt);
      return r;
    endfunction

    function void note_byte(item_t it);
      awaited.push_back(classify(it));
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no byte awaiting it, expected none, got class %0d byte %0h",
                   $time, got.byte_class, got.data_byte);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.byte_class !== want.byte_class)
        flag("byte_class", want.byte_class, got.byte_class);
      if (got.data_byte !== want.data_byte)
        flag("data_byte", want.data_byte, got.data_byte);
      if (got.chunked_mode !== want.chunked_mode)
        flag("chunked_mode", want.chunked_mode, got.chunked_mode);
      if (got.header_number !== want.header_number)
        flag("header_number", want.header_number, got.header_number);
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;
  logic                  result_valid;
  logic                  result_ready;
  result_t               result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  parse_tracker tracker;
  bit           steady;        // no random gaps on either side while set; a requested hold-off still applies
  bit           hold_request;  // ask the receiver for one long hold-off
  int unsigned  bytes_sent, responses;
  logic [LIMIT_W-1:0] mid_limit;

  http_response_header_chunk_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte, hold it until the transfer, then log its expected result.
  task automatic send_byte(input logic [7:0] b, input bit rs);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    repeat (gap) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= item_t'{stream_byte: b, restart: rs};
    do @(posedge clk); while (item_ready !== 1'b1);
    tracker.note_byte(item_t'{stream_byte: b, restart: rs});
    bytes_sent++;
  endtask

  task automatic send_crlf();
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
  endtask

  // Send a string; a position in flip gets a random nonzero byte instead.
  task automatic send_str(input string s, input int flip = -1);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = (i == flip) ? 8'($urandom_range(1, 255)) : 8'(s[i]);
      send_byte(c, 1'b0);
    end
  endtask

  // Drop valid and wait until every result has been taken.
  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_header_limit(input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_limit(value[LIMIT_W-1:0]);
  endtask

  task automatic send_size(input int unsigned size);
    string digits;
    digits = $sformatf("%0h", size);
    if ($urandom_range(0, 1)) digits = digits.toupper();
    if ($urandom_range(0, 3) == 0) send_byte("0", 1'b0);
    send_str(digits);
    if ($urandom_range(0, 6) == 0) send_str(";ext=1");
    send_crlf();
  endtask

  task automatic send_header();
    string line;
    int    flip;
    flip = -1;
    line = "";
    case ($urandom_range(0, 9))
      0, 1, 2: line = "Transfer-Encoding: chunked";
      3: line = "Transfer-Encoding: gzip";
      4: begin
        line = "Transfer-Encoding: chunked";
        flip = $urandom_range(0, 25);
      end
      5: line = "Content-Length: 12";
      6: repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0);
      7: line = "Transfer-Encoding";
      8: line = "Transfer-Encoding:chunked";
      default: line = "transfer-encoding: chunked";
    endcase
    send_str(line, flip);
    send_crlf();
  endtask

  task automatic send_chunked_body();
    string       hex_chars;
    int unsigned size;
    hex_chars = "0123456789abcdefABCDEF";
    repeat ($urandom_range(0, 3)) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      send_size(size);
      repeat (size) send_byte(8'($urandom), 1'b0);
      // the two bytes after the data are dropped whatever they hold
      if ($urandom_range(0, 7) == 0) begin
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0);
      end else begin
        send_crlf();
      end
    end
    if ($urandom_range(0, 15) == 0) begin
      // one digit more than the size counter holds, then abandon the body
      send_byte("1", 1'b0);
      repeat (SIZE_BITS / 4) send_byte(8'(hex_chars[$urandom_range(0, 21)]), 1'b0);
      send_crlf();
      repeat (3) send_byte(8'($urandom), 1'b0);
    end else if ($urandom_range(0, 4) == 0) begin
      send_crlf();
    end else begin
      send_size(0);
    end
  endtask

  // One response from a fresh start; a tenth of them are plain noise.
  task automatic random_response();
    responses++;
    if ($urandom_range(0, 9) == 0) begin
      send_byte(8'($urandom), 1'b1);
      repeat ($urandom_range(4, 20)) send_byte(8'($urandom), 1'b0);
      return;
    end
    send_byte("H", 1'b1);
    send_str("TTP/1.1 200 OK");
    send_crlf();
    repeat ($urandom_range(0, 5)) send_header();
    if ($urandom_range(0, 19) == 0) return;
    send_crlf();
    if (tracker.phase == BODY_SIZE) send_chunked_body();
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic random_traffic(input int unsigned quota);
    int unsigned first;
    first = bytes_sent;
    while (bytes_sent - first < quota) begin
      steady = ($urandom_range(0, 4) == 0);
      random_response();
    end
    steady = 1'b0;
  endtask

  // Receiver: check every transfer, stall at random, honor a long hold-off.
  initial begin
    int unsigned stall;
    stall = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid === 1'b1 && result_ready === 1'b1)
        tracker.check_result(result);
      if (stall > 0) begin
        stall--;
        result_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall        = LONG_HOLD;
        result_ready <= 1'b0;
      end else if (steady || $urandom_range(0, 99) < 70) begin
        result_ready <= 1'b1;
      end else begin
        stall        = idle_len();
        result_ready <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still awaited", cycles, tracker.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    tracker      = new();
    steady       = 1'b0;
    hold_request = 1'b0;
    bytes_sent   = 0;
    responses    = 0;
    item_valid   <= 1'b0;
    item         <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, header limit at its reset value.
    // Chunked response: extension on the size line, extreme data bytes,
    // then bytes after the body end.
    send_byte("T", 1'b1);
    send_str("ransfer-Encoding: chunked");
    send_crlf();
    send_crlf();
    send_str("a;x");
    send_crlf();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (8) send_byte(8'($urandom), 1'b0);
    send_crlf();
    send_str("0");
    send_crlf();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);

    // Lone CR inside a name, CR right after the colon, plain body.
    send_byte("X", 1'b1);
    send_byte(CH_CR, 1'b0);
    send_str("Y:");
    send_crlf();
    send_crlf();
    send_byte("q", 1'b0);

    // Size line with no digits ends the body at once.
    send_byte("T", 1'b1);
    send_str("ransfer-Encoding: chunked");
    send_crlf();
    send_crlf();
    send_crlf();

    // Name without a colon never selects chunked mode.
    send_byte("T", 1'b1);
    send_str("ransfer-Encoding");
    send_crlf();
    send_crlf();
    send_byte("5", 1'b0);

    // The first Transfer-Encoding header wins.
    send_byte("T", 1'b1);
    send_str("ransfer-Encoding: gzip");
    send_crlf();
    send_str("Transfer-Encoding: chunked");
    send_crlf();
    send_crlf();
    send_byte("1", 1'b0);

    // Size wider than the counter saturates.
    send_byte("T", 1'b1);
    send_str("ransfer-Encoding: chunked");
    send_crlf();
    send_crlf();
    send_str("FFFFFFF");
    send_crlf();
    send_byte(8'($urandom), 1'b0);

    // Hold the receiver off while bytes keep coming, so the result buffer
    // fills and item_ready drops.
    hold_request = 1'b1;
    steady       = 1'b1;
    random_response();
    random_response();
    steady = 1'b0;
    random_traffic(120);
    drain();

    // Zero limit: the first line end already overflows, empty line too.
    write_header_limit(32'd0);
    send_byte("a", 1'b1);
    send_crlf();
    send_byte("b", 1'b0);
    send_byte(CH_CR, 1'b1);
    send_byte(CH_LF, 1'b0);
    drain();

    // Limit of one: the empty line after one header overflows.
    write_header_limit(32'd1);
    send_byte("A", 1'b1);
    send_str(": b");
    send_crlf();
    send_crlf();
    send_byte("z", 1'b0);
    random_traffic(30);
    drain();

    // Small random limit with junk in the upper write bits.
    mid_limit = LIMIT_W'($urandom_range(2, 6));
    write_header_limit({$urandom} & ~32'h7FF | 32'(mid_limit));
    random_traffic(60);
    drain();

    // All ones: limit 2047 is capped at MAX_HEADERS.
    write_header_limit(32'hFFFF_FFFF);
    random_traffic(40);
    drain();

    // Limit exactly at the cap.
    write_header_limit(32'd1024);
    random_traffic(40);
    drain();
    repeat (4) @(posedge clk);

    $display("covered %0d bytes in %0d random responses plus directed cases, %0d results checked",
             bytes_sent, responses, tracker.checked);
    $display("header limits: reset value, 0, 1, %0d, 2047 capped, 1024", mid_limit);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/hrcd_pkg.sv
rtl/core/http_response_header_chunk_decoder_top.sv
verif/http_response_header_chunk_decoder_top_tb.sv
